FILE: hw/rtl/dpmc_pkg.sv
`default_nettype none

package dpmc_pkg;

   // key and count geometry
   localparam int DIGITS      = 18;
   localparam int COUNT_BITS  = 20;
   localparam int KEY_BITS    = DIGITS;
   localparam int TABLE_DEPTH = 1 << KEY_BITS;

   // item field widths
   localparam int ACTION_BITS  = 2;
   localparam int VALUE_BITS   = 60;
   localparam int PATTERN_BITS = 18;
   localparam int OUT_BITS     = 20;

   // binary to BCD conversion: value bits consumed per cycle
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_BITS / BITS_PER_STEP;
   localparam int STEP_BITS     = $clog2(CONV_STEPS);
   localparam int BCD_BITS      = 4 * DIGITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // item actions
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   // converter status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } bcd_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dpmc_ram.sv
`default_nettype none

module dpmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dpmc_bcd.sv
`default_nettype none

module dpmc_bcd (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [dpmc_pkg::VALUE_BITS-1:0]   value,
   output logic      [dpmc_pkg::KEY_BITS-1:0]     key,
   output dpmc_pkg::bcd_status_type               status
);

   import dpmc_pkg::*;

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS-1:0] val_v;
   logic [BCD_BITS-1:0]   bcd_v;

   // double-dabble, several bits per cycle; digits above the top one drop out,
   // so the result is the value modulo 10^DIGITS
   always_comb begin
      val_v = val_ff;
      bcd_v = bcd_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_v[4*d +: 4] >= 4'd5) begin
               bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
            end
         end
         bcd_v = {bcd_v[BCD_BITS-2:0], val_v[VALUE_BITS-1]};
         val_v = {val_v[VALUE_BITS-2:0], 1'b0};
      end
   end

   // step control
   always_comb begin
      val_in  = val_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         val_in  = value;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = val_v;
         bcd_in  = bcd_v;
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(CONV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      val_ff <= val_in;
      bcd_ff <= bcd_in;
   end

   // parity of each decimal digit is the low bit of its nibble
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         key[d] = bcd_ff[4*d];
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/digit_parity_multiset_counter.sv
`default_nettype none

// Channel  Direction  Ports                                      Handshake
// req      in         req_action, req_value, req_pattern         req_valid / req_ready
// rsp      out        rsp_count                                  rsp_valid / rsp_ready
//
// Add/remove: accept, conversion in the BCD unit (4 value bits per cycle),
// done, then read and write of the count RAM.
// Query: accept, RAM read, result load; action 3 is accepted and dropped.
// After reset a clearing pass zeroes the count RAM, one entry a cycle,
// with req_ready low.
// A pending result holds in the rsp register; a query waits only if it is still full.

module digit_parity_multiset_counter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [dpmc_pkg::ACTION_BITS-1:0]   req_action,
   input  wire logic [dpmc_pkg::VALUE_BITS-1:0]    req_value,
   input  wire logic [dpmc_pkg::PATTERN_BITS-1:0]  req_pattern,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [dpmc_pkg::OUT_BITS-1:0]      rsp_count
);

   import dpmc_pkg::*;

   typedef enum logic [4:0] {
      ST_CLR  = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_CONV = 5'b00100,
      ST_RD   = 5'b01000,
      ST_UPD  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [KEY_BITS-1:0]   clr_addr_ff, clr_addr_in;
   action_type            act_ff, act_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic                  bcd_start;
   logic [KEY_BITS-1:0]   bcd_key;
   bcd_status_type        bcd_status;

   logic                  ram_wr_en;
   logic [KEY_BITS-1:0]   ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [COUNT_BITS-1:0] ram_rd_data;
   logic                  accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   dpmc_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (req_value),
      .key    (bcd_key),
      .status (bcd_status)
   );

   dpmc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (key_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      bcd_start    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = key_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + KEY_BITS'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               act_in = action_type'(req_action);
               unique case (req_action) inside
                  ACT_ADD, ACT_REMOVE: begin
                     bcd_start = 1'b1;
                     state_in  = ST_CONV;
                  end
                  ACT_QUERY: begin
                     key_in   = req_pattern[KEY_BITS-1:0];
                     state_in = ST_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            if (bcd_status.done) begin
               key_in   = bcd_key;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_UPD;
         end
         ST_UPD: begin
            unique case (act_ff)
               ACT_ADD: begin
                  ram_wr_en = 1'b1;
                  if (ram_rd_data != COUNT_MAX) begin
                     ram_wr_data = ram_rd_data + COUNT_BITS'(1);
                  end
                  state_in = ST_IDLE;
               end
               ACT_REMOVE: begin
                  ram_wr_en = 1'b1;
                  if (ram_rd_data != '0) begin
                     ram_wr_data = ram_rd_data - COUNT_BITS'(1);
                  end
                  state_in = ST_IDLE;
               end
               default: begin
                  // query: wait for the result register to free up
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_in = 1'b1;
                     rsp_count_in = OUT_BITS'(ram_rd_data);
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      key_ff       <= key_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

endmodule

`default_nettype wire
